/* rtl/mssd_pkg.sv */
// Shared types, constants and functions for the seven-segment display driver.
package mssd_pkg;

	localparam int MAX_DIGITS_DEF = 8;
	localparam int VALUE_W        = 31;
	localparam int DIGIT_W        = 4;
	localparam int CNT_W          = 4;
	localparam int DEC_W          = 3;
	localparam int POS_W          = 3;
	localparam int LINES_W        = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 4;
	localparam int Q_DEPTH        = 2;
	localparam int QPTR_W         = $clog2(Q_DEPTH);
	localparam int MUL_W          = 32;
	localparam int PROD_W         = 2 * MUL_W;
	localparam int RECIP_SHIFT    = 35;

	localparam logic [MUL_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

	localparam logic [CNT_W-1:0] DIGIT_COUNT_RST   = 4'd4;
	localparam logic [DEC_W-1:0] DECIMAL_COUNT_RST = 3'd0;
	localparam logic             ACTIVE_HIGH_RST   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH   = 2'd2;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SPLIT
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] digit_count;
		logic [DEC_W-1:0] decimal_count;
		logic             active_high;
	} cfg_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] dc,
			input logic [CNT_W-1:0] max_d);
		logic [CNT_W-1:0] n;
		if (dc == '0) begin
			n = CNT_W'(1);
		end else if (dc > max_d) begin
			n = max_d;
		end else begin
			n = dc;
		end
		return n;
	endfunction

	function automatic logic [LINES_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [LINES_W-1:0] s;
		unique case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

/* rtl/mssd_if.sv */
// Valid/ready channel interfaces for display items and display results.
interface mssd_in_if;
	import mssd_pkg::*;
	logic               valid;
	logic               ready;
	logic               func;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface mssd_out_if;
	import mssd_pkg::*;
	logic               valid;
	logic               ready;
	logic [LINES_W-1:0] segment_lines;
	logic [LINES_W-1:0] digit_lines;
	logic [POS_W-1:0]   scan_position;
	modport source (output valid, output segment_lines, output digit_lines,
		output scan_position, input ready);
	modport sink (input valid, input segment_lines, input digit_lines,
		input scan_position, output ready);
endinterface

/* rtl/mssd_front.sv */
// Front end: accept items, classify them and hold them in a short command queue.
module mssd_front (
	input  logic          clk,
	input  logic          arst_n,
	mssd_in_if.sink       in_ch,
	output logic          cmd_valid,
	output mssd_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import mssd_pkg::*;

	cmd_t              entry_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;
	cmd_t              cmd_in;

	assign in_ch.ready = (count_q != (QPTR_W + 1)'(Q_DEPTH));
	assign push        = in_ch.valid && in_ch.ready;
	assign pop         = cmd_pop && cmd_valid;
	assign cmd_valid   = (count_q != '0);
	assign cmd         = entry_q[rd_ptr_q];

	always_comb begin
		cmd_in.op    = in_ch.func ? OP_TICK : OP_LOAD;
		cmd_in.value = in_ch.value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/mssd_back.sv */
// Back end: split load values into digits and answer scan ticks with display lines.
module mssd_back #(
	parameter int MAX_DIGITS = mssd_pkg::MAX_DIGITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mssd_pkg::cfg_t cfg,
	input  logic           cmd_valid,
	input  mssd_pkg::cmd_t cmd,
	output logic           cmd_pop,
	mssd_out_if.source     out_ch
);
	import mssd_pkg::*;

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	state_t              state_q;
	state_t              state_d;
	logic [IDX_W-1:0]    pos_q;
	logic [VALUE_W-1:0]  val_q;
	logic [DIGIT_W-1:0]  digit_q [MAX_DIGITS];
	logic [POS_W-1:0]    scan_q;
	logic                out_valid_q;
	logic [LINES_W-1:0]  seg_q;
	logic [LINES_W-1:0]  dig_q;
	logic [POS_W-1:0]    scan_out_q;

	logic                load_start;
	logic                tick_fire;
	logic [CNT_W-1:0]    n;
	logic [PROD_W-1:0]   prod;
	logic [VALUE_W-1:0]  quot;
	logic [VALUE_W-1:0]  rem_full;
	logic [CNT_W-1:0]    next_w;
	logic [POS_W-1:0]    next_pos;
	logic [CNT_W-1:0]    dc_w;
	logic                dp_hit;
	logic [LINES_W-1:0]  seg_raw;
	logic [LINES_W-1:0]  dig_raw;

	assign n        = eff_count(cfg.digit_count, CNT_W'(MAX_DIGITS));
	assign prod     = MUL_W'(val_q) * RECIP_10;
	assign quot     = VALUE_W'(prod >> RECIP_SHIFT);
	assign rem_full = val_q - (quot << 3) - (quot << 1);

	assign next_w   = {1'b0, scan_q} + CNT_W'(1);
	assign next_pos = (next_w >= n) ? '0 : next_w[POS_W-1:0];
	assign dc_w     = {1'b0, cfg.decimal_count};
	assign dp_hit   = (cfg.decimal_count != '0) && (dc_w < n)
		&& ((n - dc_w - CNT_W'(1)) == {1'b0, next_pos});
	assign seg_raw  = seg_pattern(digit_q[next_pos[IDX_W-1:0]]) | {dp_hit, 7'b0};
	assign dig_raw  = LINES_W'(1) << next_pos;

	assign out_ch.valid         = out_valid_q;
	assign out_ch.segment_lines = seg_q;
	assign out_ch.digit_lines   = dig_q;
	assign out_ch.scan_position = scan_out_q;

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		load_start = 1'b0;
		tick_fire  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == OP_LOAD) begin
						cmd_pop    = 1'b1;
						load_start = 1'b1;
						state_d    = ST_SPLIT;
					end else if (!out_valid_q || out_ch.ready) begin
						cmd_pop   = 1'b1;
						tick_fire = 1'b1;
					end
				end
			end
			ST_SPLIT: begin
				if (pos_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_start) begin
			val_q <= cmd.value;
			pos_q <= IDX_W'(n - CNT_W'(1));
		end else if (state_q == ST_SPLIT) begin
			val_q <= quot;
			pos_q <= pos_q - 1'b1;
		end
		if (tick_fire) begin
			seg_q      <= cfg.active_high ? seg_raw : ~seg_raw;
			dig_q      <= cfg.active_high ? dig_raw : ~dig_raw;
			scan_out_q <= next_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < MAX_DIGITS; p++) begin
				digit_q[p] <= '0;
			end
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_start) begin
				for (int p = 0; p < MAX_DIGITS; p++) begin
					if (p >= int'(n)) begin
						digit_q[p] <= '0;
					end
				end
			end else if (state_q == ST_SPLIT) begin
				digit_q[pos_q] <= rem_full[DIGIT_W-1:0];
			end
			if (tick_fire) begin
				scan_q      <= next_pos;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/multiplexed_seven_segment_driver_top.sv */
// Top level of the multiplexed seven-segment display driver.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        func, value
//   out_ch   out  valid/ready        segment_lines, digit_lines, scan_position
//   cfg      in   cfg_we (no stall)  cfg_index, cfg_data
//
// A tick is answered from idle into the output register; a load is split
// one decimal digit per cycle through the back end's reciprocal multiplier.
// The front queue holds two items, so it can take input while a load splits.
// A result waits in the output register; further ticks stall until it is taken.
// Reset clears the digit store and scan position and resets the configuration.
module multiplexed_seven_segment_driver_top #(
	parameter int MAX_DIGITS = mssd_pkg::MAX_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mssd_in_if.sink                            in_ch,
	mssd_out_if.source                         out_ch,
	input  logic                               cfg_we,
	input  logic [mssd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mssd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import mssd_pkg::*;

	cfg_t             cfg_q;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_pop;
	logic [CNT_W-1:0] eff_n;

	assign eff_n = eff_count(cfg_q.digit_count, CNT_W'(MAX_DIGITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.digit_count   <= DIGIT_COUNT_RST;
			cfg_q.decimal_count <= DECIMAL_COUNT_RST;
			cfg_q.active_high   <= ACTIVE_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DIGIT_COUNT:   cfg_q.digit_count   <= cfg_data[CNT_W-1:0];
				REG_DECIMAL_COUNT: cfg_q.decimal_count <= cfg_data[DEC_W-1:0];
				REG_ACTIVE_HIGH:   cfg_q.active_high   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mssd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	mssd_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_ch    (out_ch)
	);

`ifndef SYNTHESIS
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ({1'b0, out_ch.scan_position} < eff_n))
		else $error("scan position beyond digit count");

	a_digit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> $onehot(cfg_q.active_high ? out_ch.digit_lines
			: ~out_ch.digit_lines))
		else $error("digit enables not one-hot");
`endif

endmodule

/* bench/mssd_display_checker.sv */
`timescale 1ns / 1ps
// Frame predictor and result checker for the seven-segment display driver.
module mssd_display_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	mssd_in_if                              in_mon,
	mssd_out_if                             out_mon,
	input  logic                            cfg_we,
	input  logic [mssd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mssd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              failures,
	output int                              outstanding
);
	import mssd_pkg::*;

	typedef struct packed {
		logic [LINES_W-1:0] segment_lines;
		logic [LINES_W-1:0] digit_lines;
		logic [POS_W-1:0]   scan_position;
	} frame_t;

	logic [DIGIT_W-1:0] digits [MAX_DIGITS_DEF];
	logic [POS_W-1:0]   shown_pos;
	logic [CNT_W-1:0]   cfg_digits;
	logic [DEC_W-1:0]   cfg_decimals;
	logic               cfg_active_high;
	frame_t             expected_frames [$];

	function automatic int positions_in_use();
		int n;
		n = int'(cfg_digits);
		if (n < 1) begin
			n = 1;
		end
		if (n > MAX_DIGITS_DEF) begin
			n = MAX_DIGITS_DEF;
		end
		return n;
	endfunction

	function automatic logic [LINES_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [LINES_W-1:0] s;
		case (d)
			4'd0: s = 8'h3F;
			4'd1: s = 8'h06;
			4'd2: s = 8'h5B;
			4'd3: s = 8'h4F;
			4'd4: s = 8'h66;
			4'd5: s = 8'h6D;
			4'd6: s = 8'h7D;
			4'd7: s = 8'h07;
			4'd8: s = 8'h7F;
			4'd9: s = 8'h6F;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	task automatic store_digits(input logic [VALUE_W-1:0] v);
		int n;
		logic [VALUE_W-1:0] rest;
		n = positions_in_use();
		rest = v;
		for (int p = 0; p < MAX_DIGITS_DEF; p++) begin
			if (p >= n) begin
				digits[p] = '0;
			end
		end
		for (int p = n - 1; p >= 0; p--) begin
			digits[p] = DIGIT_W'(rest % 10);
			rest = rest / 10;
		end
	endtask

	task automatic advance_scan();
		frame_t f;
		int n;
		int nxt;
		int dp;
		n = positions_in_use();
		nxt = int'(shown_pos) + 1;
		if (nxt >= n) begin
			nxt = 0;
		end
		shown_pos = POS_W'(nxt);
		f.segment_lines = glyph(digits[shown_pos]);
		dp = n - int'(cfg_decimals) - 1;
		if (cfg_decimals != '0 && dp >= 0 && dp == int'(shown_pos)) begin
			f.segment_lines[7] = 1'b1;
		end
		f.digit_lines = LINES_W'(1) << shown_pos;
		if (!cfg_active_high) begin
			f.segment_lines = ~f.segment_lines;
			f.digit_lines = ~f.digit_lines;
		end
		f.scan_position = shown_pos;
		expected_frames.push_back(f);
	endtask

	always @(posedge clk or negedge arst_n) begin : frame_track
		frame_t got;
		frame_t want;
		if (!arst_n) begin
			for (int p = 0; p < MAX_DIGITS_DEF; p++) begin
				digits[p] = '0;
			end
			shown_pos = '0;
			cfg_digits = DIGIT_COUNT_RST;
			cfg_decimals = DECIMAL_COUNT_RST;
			cfg_active_high = ACTIVE_HIGH_RST;
			expected_frames.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DIGIT_COUNT: cfg_digits = cfg_data[CNT_W-1:0];
					REG_DECIMAL_COUNT: cfg_decimals = cfg_data[DEC_W-1:0];
					REG_ACTIVE_HIGH: cfg_active_high = cfg_data[0];
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				if (in_mon.func == OP_TICK) begin
					advance_scan();
				end else begin
					store_digits(in_mon.value);
				end
			end
			if (out_mon.valid && out_mon.ready) begin
				got.segment_lines = out_mon.segment_lines;
				got.digit_lines = out_mon.digit_lines;
				got.scan_position = out_mon.scan_position;
				if (expected_frames.size() == 0) begin
					if (failures < 10) begin
						$display("%0t: unexpected result seg=%h dig=%h pos=%0d", $realtime,
							got.segment_lines, got.digit_lines, got.scan_position);
					end
					failures = failures + 1;
				end else begin
					want = expected_frames.pop_front();
					if (got.segment_lines !== want.segment_lines
							|| got.digit_lines !== want.digit_lines
							|| got.scan_position !== want.scan_position) begin
						if (failures < 10) begin
							$display("%0t: mismatch seg=%h/%h dig=%h/%h pos=%0d/%0d (exp/act)",
								$realtime, want.segment_lines, got.segment_lines,
								want.digit_lines, got.digit_lines,
								want.scan_position, got.scan_position);
						end
						failures = failures + 1;
					end
				end
			end
			outstanding <= expected_frames.size();
		end
	end

endmodule

/* bench/tb_multiplexed_seven_segment_driver_top.sv */
`timescale 1ns / 1ps
// Testbench top for the seven-segment display driver: stimulus, register writes, verdict.
module tb_multiplexed_seven_segment_driver_top;
	import mssd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES   = 40;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int PHASES          = 16;
	localparam int LONG_HOLD       = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    failures;
	int                    outstanding;
	bit                    idling = 1'b1;
	int                    hold_off_cycles = 0;

	mssd_in_if  in_ch ();
	mssd_out_if out_ch ();

	multiplexed_seven_segment_driver_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mssd_display_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_item(input op_t op, input logic [VALUE_W-1:0] v);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= op;
		in_ch.value <= v;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] count,
			input logic [CFG_DATA_W-1:0] decimals, input logic [CFG_DATA_W-1:0] polarity);
		cfg_we <= 1'b1;
		cfg_index <= REG_DIGIT_COUNT;
		cfg_data <= count;
		@(posedge clk);
		cfg_index <= REG_DECIMAL_COUNT;
		cfg_data <= decimals;
		@(posedge clk);
		cfg_index <= REG_ACTIVE_HIGH;
		cfg_data <= polarity;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 4))
			0: return VALUE_W'($urandom());
			1: return VALUE_W'($urandom_range(0, 99));
			2: return VALUE_W'($urandom_range(0, 99_999_999));
			3: return VALUE_W'($urandom_range(0, 9_999));
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return VALUE_W'(99_999_999);
					default: return VALUE_W'(10 ** $urandom_range(0, 9));
				endcase
			end
		endcase
	endfunction

	initial begin : result_sink
		bit held;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && hold_off_cycles > 0) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
			end else if (idling && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [CNT_W-1:0] count;
		logic [DEC_W-1:0] decimals;
		logic             polarity;
		in_ch.valid = 1'b0;
		in_ch.func = OP_LOAD;
		in_ch.value = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIGIT_COUNT;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_TICK, '0);
		send_item(OP_LOAD, VALUE_W'(1234));
		repeat (4) send_item(OP_TICK, '1);
		drain();
		set_config(4'd8, 4'd3, 4'd0);
		send_item(OP_LOAD, '1);
		repeat (6) send_item(OP_TICK, '0);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data <= 4'hF;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		set_config(4'd0, 4'd5, 4'd1);
		send_item(OP_LOAD, VALUE_W'(9));
		repeat (2) send_item(OP_TICK, '0);
		drain();
		set_config(4'd15, 4'd7, 4'd0);
		send_item(OP_LOAD, VALUE_W'(98_765_432));
		repeat (2) send_item(OP_TICK, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin count = 4'd1; decimals = 3'd0; polarity = 1'b1; end
				1: begin count = 4'd8; decimals = 3'd7; polarity = 1'b0; end
				2: begin count = 4'd8; decimals = 3'd0; polarity = 1'b1; end
				3: begin count = 4'd0; decimals = 3'd1; polarity = 1'b0; end
				4: begin count = 4'd15; decimals = 3'd7; polarity = 1'b1; end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						count = CNT_W'($urandom_range(0, 15));
					end else begin
						count = CNT_W'($urandom_range(1, 8));
					end
					decimals = DEC_W'($urandom_range(0, 7));
					polarity = 1'($urandom_range(0, 1));
				end
			endcase
			set_config(count, {1'($urandom_range(0, 1)), decimals}, {3'($urandom()), polarity});
			idling = (ph != PHASES - 1) && (ph % 4 != 3);
			if (ph == 5) begin
				hold_off_cycles = LONG_HOLD;
			end
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 9) < 3) begin
					send_item(OP_LOAD, pick_value());
				end else begin
					send_item(OP_TICK, VALUE_W'($urandom()));
				end
			end
		end
		drain();

		if (failures == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
